// ===== sv/lms_pkg.sv =====
// ----------------------------------------------------------------------------
// lms_pkg
// Shared types and constants for the latch map rotary selector.
// ----------------------------------------------------------------------------
package lms_pkg;

    localparam int LATCHES_DEF = 32;
    localparam int POS_W       = 64;
    localparam int POS_CNT_W   = 6;

    localparam logic [1:0] KIND_SENSE   = 2'd0;
    localparam logic [1:0] KIND_SELECT  = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       en;
        logic [5:0] idx;
        logic       val;
    } t_map_wr;

endpackage

// ===== sv/latch_map_rotary_selector_top.sv =====
// ----------------------------------------------------------------------------
// latch_map_rotary_selector_top
// Latch closed map with sense, encoder select and release transactions.
// ----------------------------------------------------------------------------
// Sense, release and unused kinds, and a select with no latch closed, go straight
// to the done state; no new transaction is taken until the result has left it.
// Select otherwise: bit-serial modulo (one position bit per cycle), then a
// map walk over up to LATCHES latches (one latch per cycle); one transaction at a time.
// A new transaction is taken while the previous result waits in the output reg.
// Reset clears the latch map, the closed count and all control state.
// ----------------------------------------------------------------------------
module latch_map_rotary_selector_top #(
    parameter int LATCHES = lms_pkg::LATCHES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_latch_index,
    input  logic        i_latch_closed,
    input  logic [63:0] i_encoder_position,
    input  logic [6:0]  i_release_choice,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_selection,
    output logic [5:0]  o_closed_count,
    output logic        o_none_closed,
    output logic [4:0]  o_released_index,
    output logic        o_release_done
);

    localparam int IDX_W = (LATCHES > 1) ? $clog2(LATCHES) : 1;
    localparam int CNT_W = $clog2(LATCHES + 1);

    lms_pkg::t_state  r_state, n_state;
    lms_pkg::t_map_wr map_wr;

    logic [LATCHES-1:0] map;
    logic [CNT_W-1:0]   count;
    logic               accept;
    logic               mod_start, mod_done;
    logic [CNT_W-1:0]   rank;
    logic               rank_done;
    logic [IDX_W-1:0]   rank_idx;
    logic               out_free;
    logic               load_out;
    logic               sense_ok, release_ok;
    logic [6:0]         choice_m1;
    logic [IDX_W+6:0]   sel_ext;
    logic [CNT_W+5:0]   cnt_ext;

    logic       r_sel_none;
    logic [5:0] r_sel;
    logic       r_none;
    logic [4:0] r_rel_idx;
    logic       r_rel_done;

    logic       r_out_valid;
    logic [5:0] r_o_sel, r_o_cnt;
    logic       r_o_none;
    logic [4:0] r_o_rel_idx;
    logic       r_o_rel_done;

    assign accept     = i_in_valid && o_in_ready;
    assign sense_ok   = ({1'b0, i_latch_index} < 7'(LATCHES));
    assign release_ok = (i_release_choice != 7'd0) && (i_release_choice <= 7'(LATCHES));
    assign choice_m1  = i_release_choice - 7'd1;
    assign out_free   = !r_out_valid || i_out_ready;
    assign sel_ext    = {7'd0, rank_idx} + (IDX_W + 7)'(1);
    assign cnt_ext    = {6'd0, count};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lms_pkg::ST_IDLE: begin
                if (accept) begin
                    if ((i_kind == lms_pkg::KIND_SELECT) && (count != '0)) begin
                        n_state = lms_pkg::ST_MOD;
                    end else begin
                        n_state = lms_pkg::ST_DONE;
                    end
                end
            end
            lms_pkg::ST_MOD: begin
                if (mod_done) begin
                    n_state = lms_pkg::ST_SCAN;
                end
            end
            lms_pkg::ST_SCAN: begin
                if (rank_done) begin
                    n_state = lms_pkg::ST_DONE;
                end
            end
            lms_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = lms_pkg::ST_IDLE;
                end
            end
            default: n_state = lms_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        mod_start  = 1'b0;
        load_out   = 1'b0;
        map_wr     = '0;
        unique case (r_state)
            lms_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                mod_start  = accept && (i_kind == lms_pkg::KIND_SELECT) && (count != '0);
                if (accept && (i_kind == lms_pkg::KIND_SENSE) && sense_ok) begin
                    map_wr.en  = 1'b1;
                    map_wr.idx = i_latch_index;
                    map_wr.val = i_latch_closed;
                end else if (accept && (i_kind == lms_pkg::KIND_RELEASE) && release_ok) begin
                    map_wr.en  = 1'b1;
                    map_wr.idx = choice_m1[5:0];
                    map_wr.val = 1'b0;
                end
            end
            lms_pkg::ST_DONE: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lms_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sel_none <= (i_kind == lms_pkg::KIND_SELECT) && (count == '0);
            r_none     <= (i_kind == lms_pkg::KIND_SELECT) && (count == '0);
            r_sel      <= ((i_kind == lms_pkg::KIND_SELECT) && (count == '0)) ? 6'd1 : 6'd0;
            r_rel_done <= (i_kind == lms_pkg::KIND_RELEASE) && release_ok;
            r_rel_idx  <= ((i_kind == lms_pkg::KIND_RELEASE) && release_ok) ?
                          choice_m1[4:0] : 5'd0;
        end else if (rank_done && !r_sel_none) begin
            r_sel <= sel_ext[5:0];
        end
        if (load_out) begin
            r_o_sel      <= r_sel;
            r_o_cnt      <= cnt_ext[5:0];
            r_o_none     <= r_none;
            r_o_rel_idx  <= r_rel_idx;
            r_o_rel_done <= r_rel_done;
        end
    end

    lms_map #(
        .LATCHES (LATCHES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (map_wr),
        .o_map   (map),
        .o_count (count)
    );

    lms_divmod #(
        .CNT_W (CNT_W)
    ) u_divmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_pos   (i_encoder_position),
        .i_n     (count),
        .o_done  (mod_done),
        .o_rank  (rank)
    );

    lms_rank #(
        .LATCHES (LATCHES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_done),
        .i_rank  (rank),
        .i_map   (map),
        .o_done  (rank_done),
        .o_idx   (rank_idx)
    );

    assign o_out_valid      = r_out_valid;
    assign o_selection      = r_o_sel;
    assign o_closed_count   = r_o_cnt;
    assign o_none_closed    = r_o_none;
    assign o_released_index = r_o_rel_idx;
    assign o_release_done   = r_o_rel_done;

endmodule

// ===== sv/lms_map.sv =====
// ----------------------------------------------------------------------------
// lms_map
// Latch closed bits with a running count of closed latches.
// ----------------------------------------------------------------------------
module lms_map #(
    parameter int LATCHES = lms_pkg::LATCHES_DEF,
    parameter int IDX_W   = (LATCHES > 1) ? $clog2(LATCHES) : 1,
    parameter int CNT_W   = $clog2(LATCHES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lms_pkg::t_map_wr    i_wr,
    output logic [LATCHES-1:0]  o_map,
    output logic [CNT_W-1:0]    o_count
);

    logic [LATCHES-1:0] r_map, n_map;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   wr_idx;
    logic               old_bit;

    assign wr_idx  = i_wr.idx[IDX_W-1:0];
    assign old_bit = r_map[wr_idx];

    always_comb begin
        n_map   = r_map;
        n_count = r_count;
        if (i_wr.en && (old_bit != i_wr.val)) begin
            n_map[wr_idx] = i_wr.val;
            if (i_wr.val) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
            r_count <= '0;
        end else begin
            r_map   <= n_map;
            r_count <= n_count;
        end
    end

    assign o_map   = r_map;
    assign o_count = r_count;

endmodule

// ===== sv/lms_divmod.sv =====
// ----------------------------------------------------------------------------
// lms_divmod
// Bit-serial non-negative modulo of a signed 64-bit position by the count.
// ----------------------------------------------------------------------------
module lms_divmod #(
    parameter int CNT_W = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lms_pkg::POS_W-1:0]  i_pos,
    input  logic [CNT_W-1:0]           i_n,
    output logic                       o_done,
    output logic [CNT_W-1:0]           o_rank
);

    logic [lms_pkg::POS_W-1:0]     r_sh;
    logic [CNT_W-1:0]              r_rem;
    logic [CNT_W-1:0]              r_n;
    logic                          r_neg;
    logic [lms_pkg::POS_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W:0]                trial;
    logic [CNT_W:0]                diff;
    logic [CNT_W-1:0]              step_rem;

    assign trial    = {r_rem, r_sh[lms_pkg::POS_W-1]};
    assign diff     = trial - {1'b0, r_n};
    assign step_rem = (trial >= {1'b0, r_n}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_pos[lms_pkg::POS_W-1] ? (~i_pos + (lms_pkg::POS_W)'(1)) : i_pos;
            r_neg <= i_pos[lms_pkg::POS_W-1];
            r_n   <= i_n;
            r_rem <= '0;
            r_cnt <= '1;
        end else if (r_busy) begin
            r_sh  <= {r_sh[lms_pkg::POS_W-2:0], 1'b0};
            r_rem <= step_rem;
            r_cnt <= r_cnt - (lms_pkg::POS_CNT_W)'(1);
        end
    end

    assign o_done = r_done;
    assign o_rank = (r_neg && (r_rem != '0)) ? (r_n - r_rem) : r_rem;

endmodule

// ===== sv/lms_rank.sv =====
// ----------------------------------------------------------------------------
// lms_rank
// Walks the latch map one bit per cycle to find the closed latch of a rank.
// ----------------------------------------------------------------------------
module lms_rank #(
    parameter int LATCHES = lms_pkg::LATCHES_DEF,
    parameter int IDX_W   = (LATCHES > 1) ? $clog2(LATCHES) : 1,
    parameter int CNT_W   = $clog2(LATCHES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [CNT_W-1:0]   i_rank,
    input  logic [LATCHES-1:0] i_map,
    output logic               o_done,
    output logic [IDX_W-1:0]   o_idx
);

    logic [CNT_W-1:0] r_rank;
    logic [CNT_W-1:0] r_seen;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_idx;
    logic             r_busy;
    logic             r_done;
    logic             hit;
    logic             last;

    assign hit  = i_map[r_i] && (r_seen == r_rank);
    assign last = (r_i == IDX_W'(LATCHES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (hit || last)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rank <= i_rank;
            r_seen <= '0;
            r_i    <= '0;
            r_idx  <= '0;
        end else if (r_busy) begin
            if (hit) begin
                r_idx <= r_i;
            end
            if (i_map[r_i]) begin
                r_seen <= r_seen + CNT_W'(1);
            end
            r_i <= r_i + IDX_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_idx  = r_idx;

endmodule
